FILE: rtl/dsp_pkg.sv
package dsp_pkg;

  // Graph size and weight precision.
  localparam int NUM_VERTICES = 16;
  localparam int WEIGHT_BITS  = 8;

  // Fixed widths of the transaction fields.
  localparam int IDX_BITS    = 4;
  localparam int EDGE_BITS   = 8;
  localparam int DIST_BITS   = 12;

  // Derived widths.
  localparam int VTX_BITS  = $clog2(NUM_VERTICES);
  localparam int ADDR_BITS = $clog2(NUM_VERTICES * NUM_VERTICES);
  localparam int SUM_BITS  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

  localparam logic [DIST_BITS-1:0] DIST_NONE  = '1;
  localparam logic [DIST_BITS-1:0] DIST_SAT   = DIST_NONE - DIST_BITS'(1);
  localparam logic [VTX_BITS-1:0]  VTX_LAST   = VTX_BITS'(NUM_VERTICES - 1);
  localparam logic [VTX_BITS-1:0]  ROUND_LAST = VTX_BITS'(NUM_VERTICES - 2);

  // Microprogram steps.
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_INIT,
    STEP_SCAN,
    STEP_MARK,
    STEP_RELAX,
    STEP_NEXT,
    STEP_EMIT
  } step_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IN_LAST,
    COND_CNT_LAST,
    COND_BEST_NONE,
    COND_ROUND_MORE,
    COND_EMIT_LAST
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic  in_rdy;
    logic  init;
    logic  scan;
    logic  mark;
    logic  relax;
    logic  next_round;
    logic  emit;
    cond_t cond;
    step_t target;
    step_t next;
  } ucode_t;

  // Status flags that the jump conditions test.
  typedef struct packed {
    logic in_last;
    logic cnt_last;
    logic best_none;
    logic round_more;
    logic emit_last;
  } status_t;

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_IDLE;
    w.next   = STEP_IDLE;
    unique case (pc)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_IN_LAST;
        w.target = STEP_INIT;
        w.next   = STEP_IDLE;
      end
      STEP_INIT: begin
        w.init = 1'b1;
        w.next = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan   = 1'b1;
        w.cond   = COND_CNT_LAST;
        w.target = STEP_MARK;
        w.next   = STEP_SCAN;
      end
      STEP_MARK: begin
        w.mark   = 1'b1;
        w.cond   = COND_BEST_NONE;
        w.target = STEP_NEXT;
        w.next   = STEP_RELAX;
      end
      STEP_RELAX: begin
        w.relax  = 1'b1;
        w.cond   = COND_CNT_LAST;
        w.target = STEP_NEXT;
        w.next   = STEP_RELAX;
      end
      STEP_NEXT: begin
        w.next_round = 1'b1;
        w.cond       = COND_ROUND_MORE;
        w.target     = STEP_SCAN;
        w.next       = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_EMIT_LAST;
        w.target = STEP_IDLE;
        w.next   = STEP_EMIT;
      end
      default: begin
        w.next = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/dsp_in_if.sv
interface dsp_in_if;
  logic                          valid;
  logic                          ready;
  logic [dsp_pkg::IDX_BITS-1:0]  from_vertex;
  logic [dsp_pkg::IDX_BITS-1:0]  to_vertex;
  logic [dsp_pkg::EDGE_BITS-1:0] edge_weight;
  logic                          last_entry;

  modport source(output valid, from_vertex, to_vertex, edge_weight, last_entry,
                 input ready);
  modport sink(input valid, from_vertex, to_vertex, edge_weight, last_entry,
               output ready);
endinterface

FILE: rtl/dsp_out_if.sv
interface dsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [dsp_pkg::IDX_BITS-1:0]  vertex_index;
  logic [dsp_pkg::DIST_BITS-1:0] distance;
  logic                          reachable;
  logic                          last_result;

  modport source(output valid, vertex_index, distance, reachable, last_result,
                 input ready);
  modport sink(input valid, vertex_index, distance, reachable, last_result,
               output ready);
endinterface

FILE: rtl/dsp_weight_ram.sv
module dsp_weight_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [dsp_pkg::ADDR_BITS-1:0]   waddr,
  input  logic [dsp_pkg::WEIGHT_BITS-1:0] wdata,
  input  logic                            re,
  input  logic [dsp_pkg::ADDR_BITS-1:0]   raddr,
  output logic [dsp_pkg::WEIGHT_BITS-1:0] rdata_r
);

  logic [dsp_pkg::WEIGHT_BITS-1:0] mem [dsp_pkg::NUM_VERTICES * dsp_pkg::NUM_VERTICES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dsp_seq.sv
module dsp_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  dsp_pkg::status_t st,
  output dsp_pkg::ucode_t  uc
);

  dsp_pkg::step_t pc_r;
  dsp_pkg::step_t pc_nxt;
  logic           hit;

  // Step register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dsp_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Control word fetch, condition test and next step.
  always_comb begin
    uc = dsp_pkg::ucode_rom(pc_r);
    unique case (uc.cond)
      dsp_pkg::COND_NEVER:      hit = 1'b0;
      dsp_pkg::COND_IN_LAST:    hit = st.in_last;
      dsp_pkg::COND_CNT_LAST:   hit = st.cnt_last;
      dsp_pkg::COND_BEST_NONE:  hit = st.best_none;
      dsp_pkg::COND_ROUND_MORE: hit = st.round_more;
      dsp_pkg::COND_EMIT_LAST:  hit = st.emit_last;
      default:                  hit = 1'b0;
    endcase
    pc_nxt = hit ? uc.target : uc.next;
  end

endmodule

FILE: rtl/dsp_datapath.sv
module dsp_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dsp_pkg::ucode_t                 uc,
  input  logic                            in_last,
  input  logic [dsp_pkg::IDX_BITS-1:0]    src,
  input  logic [dsp_pkg::WEIGHT_BITS-1:0] rd_q,
  output logic                            rd_en,
  output logic [dsp_pkg::ADDR_BITS-1:0]   rd_addr,
  output dsp_pkg::status_t                st,
  dsp_out_if.source                       out_ch
);

  logic [dsp_pkg::DIST_BITS-1:0]    dist_r [dsp_pkg::NUM_VERTICES];
  logic [dsp_pkg::NUM_VERTICES-1:0] visited_r;
  logic [dsp_pkg::VTX_BITS-1:0]     cnt_r;
  logic [dsp_pkg::VTX_BITS-1:0]     round_r;
  logic [dsp_pkg::DIST_BITS-1:0]    best_r;
  logic [dsp_pkg::VTX_BITS-1:0]     best_idx_r;
  logic                             pend_r;
  logic [dsp_pkg::VTX_BITS-1:0]     vd_r;

  logic                             out_valid_r;
  logic [dsp_pkg::IDX_BITS-1:0]     out_idx_r;
  logic [dsp_pkg::DIST_BITS-1:0]    out_dist_r;
  logic                             out_reach_r;
  logic                             out_last_r;

  logic [dsp_pkg::VTX_BITS-1:0]     rd_idx;
  logic [dsp_pkg::DIST_BITS-1:0]    rd_d;
  logic [dsp_pkg::SUM_BITS-1:0]     sum;
  logic [dsp_pkg::DIST_BITS-1:0]    sat;
  logic                             relax_upd;
  logic                             emit_load;
  logic                             cnt_adv;
  logic                             cnt_last;
  logic                             src_ok;

  // Single read of the distance store: the pending relaxation target, else the counter.
  assign rd_idx = pend_r ? vd_r : cnt_r;
  assign rd_d   = dist_r[rd_idx];

  // Weight fetch for the row of the selected vertex.
  assign rd_en   = uc.relax;
  assign rd_addr = dsp_pkg::ADDR_BITS'(int'(best_idx_r) * dsp_pkg::NUM_VERTICES + int'(cnt_r));

  // Relaxation of one out-edge, in the cycle after its weight was fetched.
  assign sum = dsp_pkg::SUM_BITS'(best_r) + dsp_pkg::SUM_BITS'(rd_q);
  assign sat = (sum > dsp_pkg::SUM_BITS'(dsp_pkg::DIST_SAT)) ? dsp_pkg::DIST_SAT
                                                             : dsp_pkg::DIST_BITS'(sum);
  assign relax_upd = pend_r && !visited_r[vd_r] && (rd_q != '0) && (sat < rd_d);

  // Counter control.
  assign cnt_last  = (cnt_r == dsp_pkg::VTX_LAST);
  assign emit_load = uc.emit && (!out_valid_r || out_ch.ready);
  assign cnt_adv   = uc.scan || uc.relax || emit_load;
  assign src_ok    = int'(src) < dsp_pkg::NUM_VERTICES;

  // Status for the sequencer.
  assign st.in_last    = in_last;
  assign st.cnt_last   = cnt_last;
  assign st.best_none  = (best_r == dsp_pkg::DIST_NONE);
  assign st.round_more = (round_r != dsp_pkg::ROUND_LAST);
  assign st.emit_last  = emit_load && cnt_last;

  // Control state and distance store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      round_r     <= '0;
      pend_r      <= 1'b0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
      for (int v = 0; v < dsp_pkg::NUM_VERTICES; v++) begin
        dist_r[v] <= dsp_pkg::DIST_NONE;
      end
    end else begin
      pend_r <= uc.relax;
      if (cnt_adv) begin
        cnt_r <= cnt_last ? '0 : cnt_r + dsp_pkg::VTX_BITS'(1);
      end

      // Run start: distances unreachable except the source, nothing visited.
      if (uc.init) begin
        cnt_r     <= '0;
        round_r   <= '0;
        visited_r <= '0;
        for (int v = 0; v < dsp_pkg::NUM_VERTICES; v++) begin
          if (src_ok && (dsp_pkg::VTX_BITS'(src) == dsp_pkg::VTX_BITS'(v))) begin
            dist_r[v] <= '0;
          end else begin
            dist_r[v] <= dsp_pkg::DIST_NONE;
          end
        end
      end

      if (uc.mark) begin
        visited_r[best_idx_r] <= 1'b1;
      end

      if (relax_upd) begin
        dist_r[vd_r] <= sat;
      end

      if (uc.next_round) begin
        round_r <= round_r + dsp_pkg::VTX_BITS'(1);
      end

      // Output register: a new load refills, else a taken transaction clears.
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Selection and payload registers.
  always_ff @(posedge clk) begin
    if (uc.relax) begin
      vd_r <= cnt_r;
    end
    if (uc.init || uc.next_round) begin
      best_r     <= dsp_pkg::DIST_NONE;
      best_idx_r <= '0;
    end else if (uc.scan && !visited_r[cnt_r] && (rd_d <= best_r)) begin
      // Less-or-equal keeps the highest index on ties.
      best_r     <= rd_d;
      best_idx_r <= cnt_r;
    end
    if (emit_load) begin
      out_idx_r   <= dsp_pkg::IDX_BITS'(cnt_r);
      out_dist_r  <= rd_d;
      out_reach_r <= (rd_d != dsp_pkg::DIST_NONE);
      out_last_r  <= cnt_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = out_idx_r;
  assign out_ch.distance     = out_dist_r;
  assign out_ch.reachable    = out_reach_r;
  assign out_ch.last_result  = out_last_r;

endmodule

FILE: rtl/dense_shortest_path_unit.sv
// Loading: one matrix entry transaction per cycle while idle; an entry without the last flag gives
// no result. The last entry starts a run of rounds: each round scans the distance store one vertex
// a cycle, then marks the selected vertex and, if it is reachable, relaxes one out-edge a cycle
// through the weight RAM read port. Then N results leave at one per cycle as the sink takes them.
// Reset (synchronous, active low) clears the sequencer, source to 0 and distances to all ones;
// the weight RAM is not cleared.
module dense_shortest_path_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  dsp_in_if.sink                       in_ch,
  dsp_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [dsp_pkg::IDX_BITS-1:0] cfg_data
);

  dsp_pkg::ucode_t                 uc;
  dsp_pkg::status_t                st;
  logic [dsp_pkg::IDX_BITS-1:0]    src_r;
  logic                            in_acc;
  logic                            in_range;
  logic                            wr_en;
  logic [dsp_pkg::ADDR_BITS-1:0]   wr_addr;
  logic                            rd_en;
  logic [dsp_pkg::ADDR_BITS-1:0]   rd_addr;
  logic [dsp_pkg::WEIGHT_BITS-1:0] rd_q;

  // Source vertex register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
    end else if (cfg_we) begin
      src_r <= cfg_data;
    end
  end

  // Input transaction: store the entry when its row and column are in range.
  assign in_ch.ready = uc.in_rdy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_range    = (int'(in_ch.from_vertex) < dsp_pkg::NUM_VERTICES) &&
                       (int'(in_ch.to_vertex) < dsp_pkg::NUM_VERTICES);
  assign wr_en       = in_acc && in_range;
  assign wr_addr     = dsp_pkg::ADDR_BITS'(int'(in_ch.from_vertex) * dsp_pkg::NUM_VERTICES +
                                           int'(in_ch.to_vertex));

  dsp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uc    (uc)
  );

  dsp_weight_ram u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (dsp_pkg::WEIGHT_BITS'(in_ch.edge_weight)),
    .re      (rd_en),
    .raddr   (rd_addr),
    .rdata_r (rd_q)
  );

  dsp_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .uc      (uc),
    .in_last (in_acc && in_ch.last_entry),
    .src     (src_r),
    .rd_q    (rd_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .st      (st),
    .out_ch  (out_ch)
  );

endmodule
